// ----- src/sixax_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixax_pkg
// shared types and character codes for the six-axis serial packet decoder
// ----------------------------------------------------------------------------
package sixax_pkg;

  // control characters on the serial link
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_CARET = 8'h5E;
  localparam logic [7:0] CH_XON   = 8'h11;
  localparam logic [7:0] CH_XOFF  = 8'h13;
  localparam logic [7:0] CH_KEY   = 8'h4B;
  localparam logic [7:0] CH_DATA  = 8'h44;

  // escaped bytes other than a caret keep only their low five bits
  localparam logic [7:0] ESC_MASK = 8'h1F;

  // only the head of a packet is ever decoded: kind, period and six words
  localparam int READ_BYTES = 15;
  localparam int NUM_AXES   = 6;

  // decoupling queue between front and back
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic {
    KIND_BUTTON = 1'b0,
    KIND_MOTION = 1'b1
  } sixax_kind_t;

  // one classified packet, handed from front to back
  typedef struct packed {
    sixax_kind_t                  kind;
    logic [8:0]                   buttons;
    logic [15:0]                  period;
    logic [NUM_AXES-1:0][15:0]    words;
  } sixax_cmd_t;

endpackage

// ----- src/sixax_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixax_front
// byte intake: flow-control stripping, escape handling, packet assembly
// ----------------------------------------------------------------------------
module sixax_front import sixax_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output logic       push,
  output sixax_cmd_t cmd
);

  localparam int CW = $clog2(BUFFER_BYTES + 1);

  logic [7:0]    store [READ_BYTES];
  logic [CW-1:0] fill;
  logic          esc;

  logic          do_store;
  logic [7:0]    store_byte;
  logic          is_end;

  always_comb begin
    do_store   = 1'b0;
    store_byte = rx_byte;
    is_end     = 1'b0;
    if (esc) begin
      do_store = 1'b1;
      if (rx_byte != CH_CARET) begin
        store_byte = rx_byte & ESC_MASK;
      end
    end else if (rx_byte == CH_XON || rx_byte == CH_XOFF || rx_byte == CH_CARET) begin
      do_store = 1'b0;
    end else if (rx_byte == CH_CR) begin
      is_end = 1'b1;
    end else begin
      do_store = 1'b1;
    end
  end

  assign push = accept && is_end && (fill != '0) &&
                (store[0] == CH_KEY || store[0] == CH_DATA);

  always_comb begin
    cmd.kind    = (store[0] == CH_DATA) ? KIND_MOTION : KIND_BUTTON;
    cmd.buttons = {store[1][4:0], store[2][3:0]};
    cmd.period  = {store[1], store[2]};
    for (int j = 0; j < NUM_AXES; j++) begin
      cmd.words[j] = {store[3 + 2 * j], store[4 + 2 * j]};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
      esc  <= 1'b0;
      for (int i = 0; i < READ_BYTES; i++) begin
        store[i] <= '0;
      end
    end else if (accept) begin
      if (esc) begin
        esc <= 1'b0;
      end else if (rx_byte == CH_CARET) begin
        esc <= 1'b1;
      end
      if (is_end) begin
        fill <= '0;
      end else if (do_store && fill != CW'(BUFFER_BYTES)) begin
        fill <= fill + 1'b1;
        // bytes past the decoded head are counted but never read back
        for (int i = 0; i < READ_BYTES; i++) begin
          if (fill == CW'(i)) begin
            store[i] <= store_byte;
          end
        end
      end
    end
  end

endmodule

// ----- src/sixax_queue.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixax_queue
// short fifo of classified packets between front and back
// ----------------------------------------------------------------------------
module sixax_queue import sixax_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  sixax_cmd_t push_cmd,
  input  logic       pop,
  output logic       not_empty,
  output logic       not_full,
  output sixax_cmd_t head
);

  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int NW = $clog2(QUEUE_DEPTH + 1);

  sixax_cmd_t    slots [QUEUE_DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [NW-1:0] count;

  assign not_empty = (count != '0);
  assign not_full  = (count != NW'(QUEUE_DEPTH));
  assign head      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> (not_full || pop))
    else $error("queue written while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    pop |-> not_empty)
    else $error("queue read while empty");

  a_push_fills: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> not_empty)
    else $error("queue empty after a lone push");

endmodule

// ----- src/sixax_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sixax_back
// packet execution: button delta tracking and six axis products
// ----------------------------------------------------------------------------
module sixax_back import sixax_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_valid,
  input  sixax_cmd_t          cmd,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [0:0]          packet_kind,
  output logic [8:0]          button_bits,
  output logic [8:0]          button_changes,
  output logic signed [31:0]  axis_tx,
  output logic signed [31:0]  axis_ty,
  output logic signed [31:0]  axis_tz,
  output logic signed [31:0]  axis_rx,
  output logic signed [31:0]  axis_ry,
  output logic signed [31:0]  axis_rz
);

  logic [8:0]                last_buttons;
  logic [NUM_AXES-1:0][31:0] prod;

  assign pop = cmd_valid && (!out_valid || out_ready);

  // unsigned 16 x 16 products, landing straight in the output register
  always_comb begin
    for (int j = 0; j < NUM_AXES; j++) begin
      prod[j] = 32'(cmd.period) * 32'(cmd.words[j]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid    <= 1'b0;
      last_buttons <= '0;
    end else if (pop) begin
      out_valid <= 1'b1;
      if (cmd.kind == KIND_BUTTON) begin
        last_buttons <= cmd.buttons;
      end
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      packet_kind <= cmd.kind;
      if (cmd.kind == KIND_BUTTON) begin
        button_bits    <= cmd.buttons;
        button_changes <= cmd.buttons ^ last_buttons;
        axis_tx        <= '0;
        axis_ty        <= '0;
        axis_tz        <= '0;
        axis_rx        <= '0;
        axis_ry        <= '0;
        axis_rz        <= '0;
      end else begin
        button_bits    <= '0;
        button_changes <= '0;
        axis_tx        <= prod[0];
        axis_ty        <= prod[1];
        axis_tz        <= prod[2];
        axis_rx        <= prod[3];
        axis_ry        <= prod[4];
        axis_rz        <= prod[5];
      end
    end
  end

  a_delta: assert property (@(posedge clk) disable iff (rst)
    (pop && cmd.kind == KIND_BUTTON) |=>
      (button_changes == (button_bits ^ $past(last_buttons)) &&
       last_buttons == button_bits))
    else $error("button change set does not match previous set");

  a_motion_no_buttons: assert property (@(posedge clk) disable iff (rst)
    (out_valid && packet_kind == KIND_MOTION) |-> (button_bits == '0))
    else $error("motion result carries button bits");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(packet_kind) &&
                                   $stable(axis_tx) && $stable(button_bits)))
    else $error("result changed while stalled");

endmodule

// ----- src/six_axis_serial_packet_decoder_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// six_axis_serial_packet_decoder_core
// turns a stream of serial bytes into button and six-axis motion results
// ----------------------------------------------------------------------------
//
//   channel | signals                          | payload
//   --------+----------------------------------+--------------------------------
//   in      | in_valid, in_ready               | rx_byte
//   out     | out_valid, out_ready             | packet_kind, button_bits,
//           |                                  | button_changes, axis_tx..rz
//
// one byte is taken every cycle while in_ready is high; a result can leave every cycle
// while out_ready is high; a decodable packet reaches the output as follows:
//   the front pushes it into the queue at the edge that takes the carriage
//   return, and the back multiplies it into the output register when it pops it
// in_ready falls only when the two-entry queue is full behind a stalled output
// synchronous reset clears the packet head, fill count, escape flag and button history
// ----------------------------------------------------------------------------
module six_axis_serial_packet_decoder_core import sixax_pkg::*; #(
  parameter int BUFFER_BYTES = 64
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [0:0]         packet_kind,
  output logic [8:0]         button_bits,
  output logic [8:0]         button_changes,
  output logic signed [31:0] axis_tx,
  output logic signed [31:0] axis_ty,
  output logic signed [31:0] axis_tz,
  output logic signed [31:0] axis_rx,
  output logic signed [31:0] axis_ry,
  output logic signed [31:0] axis_rz
);

  logic       accept;
  logic       push;
  logic       pop;
  logic       q_not_empty;
  logic       q_not_full;
  sixax_cmd_t push_cmd;
  sixax_cmd_t head_cmd;

  // every byte waits on queue space, so a closing byte always finds a slot
  assign in_ready = q_not_full;
  assign accept   = in_valid && in_ready;

  // front: assembles packets and classifies them at carriage return
  sixax_front #(
    .BUFFER_BYTES (BUFFER_BYTES)
  ) u_front (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx_byte),
    .push    (push),
    .cmd     (push_cmd)
  );

  // decoupling queue so a stalled output does not stop byte intake at once
  sixax_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_cmd  (push_cmd),
    .pop       (pop),
    .not_empty (q_not_empty),
    .not_full  (q_not_full),
    .head      (head_cmd)
  );

  // back: button history and axis products, held in the output register
  sixax_back u_back (
    .clk            (clk),
    .rst            (rst),
    .cmd_valid      (q_not_empty),
    .cmd            (head_cmd),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .packet_kind    (packet_kind),
    .button_bits    (button_bits),
    .button_changes (button_changes),
    .axis_tx        (axis_tx),
    .axis_ty        (axis_ty),
    .axis_tz        (axis_tz),
    .axis_rx        (axis_rx),
    .axis_ry        (axis_ry),
    .axis_rz        (axis_rz)
  );

endmodule
